/* hdl/ird_pkg.sv */
// Shared types and constants for the IR pulse-distance decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package ird_pkg;

  localparam int unsigned TIME_W   = 16;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_TUSER_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HEADER_MIN = 3'd0,
    REG_HEADER_MAX = 3'd1,
    REG_REPEAT_MIN = 3'd2,
    REG_REPEAT_MAX = 3'd3,
    REG_ZERO_MIN   = 3'd4,
    REG_ZERO_MAX   = 3'd5,
    REG_ONE_MIN    = 3'd6,
    REG_ONE_MAX    = 3'd7
  } ird_reg_t;

  localparam logic [TIME_W-1:0] RST_HEADER_MIN = 16'd12500;
  localparam logic [TIME_W-1:0] RST_HEADER_MAX = 16'd14500;
  localparam logic [TIME_W-1:0] RST_REPEAT_MIN = 16'd10800;
  localparam logic [TIME_W-1:0] RST_REPEAT_MAX = 16'd11800;
  localparam logic [TIME_W-1:0] RST_ZERO_MIN   = 16'd900;
  localparam logic [TIME_W-1:0] RST_ZERO_MAX   = 16'd1400;
  localparam logic [TIME_W-1:0] RST_ONE_MIN    = 16'd1900;
  localparam logic [TIME_W-1:0] RST_ONE_MAX    = 16'd2600;

  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

  typedef enum logic [OUT_TUSER_W-1:0] {
    EV_FIRST  = 3'd0,
    EV_HEADER = 3'd1,
    EV_REPEAT = 3'd2,
    EV_BIT    = 3'd3,
    EV_FRAME  = 3'd4,
    EV_ERROR  = 3'd5,
    EV_IGNORE = 3'd6
  } ird_event_t;

  // classified edge passed from front to back
  typedef struct packed {
    logic first;
    logic hdr;
    logic rpt;
    logic zero;
    logic one;
  } ird_class_t;

endpackage
`default_nettype wire

/* hdl/ird_front.sv */
// Front end: holds the timing windows, measures edge intervals and classifies them.
// Depends on ird_pkg.
`default_nettype none
module ird_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ird_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [ird_pkg::TIME_W-1:0]    cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [ird_pkg::TIME_W-1:0]    edge_time,
  input  wire logic                          q_full,
  output logic                               q_push,
  output ird_pkg::ird_class_t                q_class
);
  import ird_pkg::*;

  logic [TIME_W-1:0] hdr_min_r, hdr_max_r, rpt_min_r, rpt_max_r;
  logic [TIME_W-1:0] zero_min_r, zero_max_r, one_min_r, one_max_r;
  logic              seen_r, seen_nxt;
  logic [TIME_W-1:0] prev_r, prev_nxt;
  logic [TIME_W-1:0] delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_min_r  <= RST_HEADER_MIN;
      hdr_max_r  <= RST_HEADER_MAX;
      rpt_min_r  <= RST_REPEAT_MIN;
      rpt_max_r  <= RST_REPEAT_MAX;
      zero_min_r <= RST_ZERO_MIN;
      zero_max_r <= RST_ZERO_MAX;
      one_min_r  <= RST_ONE_MIN;
      one_max_r  <= RST_ONE_MAX;
    end else if (cfg_we) begin
      unique case (ird_reg_t'(cfg_index))
        REG_HEADER_MIN: hdr_min_r  <= cfg_wdata;
        REG_HEADER_MAX: hdr_max_r  <= cfg_wdata;
        REG_REPEAT_MIN: rpt_min_r  <= cfg_wdata;
        REG_REPEAT_MAX: rpt_max_r  <= cfg_wdata;
        REG_ZERO_MIN:   zero_min_r <= cfg_wdata;
        REG_ZERO_MAX:   zero_max_r <= cfg_wdata;
        REG_ONE_MIN:    one_min_r  <= cfg_wdata;
        REG_ONE_MAX:    one_max_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  // interval wraps modulo 2^16
  assign delta     = edge_time - prev_r;

  always_comb begin
    seen_nxt = seen_r;
    prev_nxt = prev_r;
    if (q_push) begin
      seen_nxt = 1'b1;
      prev_nxt = edge_time;
    end
    q_class.first = !seen_r;
    q_class.hdr   = (delta >= hdr_min_r)  && (delta <= hdr_max_r);
    q_class.rpt   = (delta >= rpt_min_r)  && (delta <= rpt_max_r);
    q_class.zero  = (delta >= zero_min_r) && (delta <= zero_max_r);
    q_class.one   = (delta >= one_min_r)  && (delta <= one_max_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      prev_r <= '0;
    end else begin
      seen_r <= seen_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/ird_queue.sv */
// Two-entry queue of classified edges between front and back.
// Depends on ird_pkg.
`default_nettype none
module ird_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  ird_pkg::ird_class_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               avail,
  output ird_pkg::ird_class_t pop_data
);
  import ird_pkg::*;

  ird_class_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign avail    = (count_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/ird_back.sv */
// Back end: reception state, bit assembly, frame check and the output register.
// Depends on ird_pkg.
`default_nettype none
module ird_back #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_avail,
  input  ird_pkg::ird_class_t                  q_class,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [ird_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [ird_pkg::OUT_TUSER_W-1:0]      out_tuser
);
  import ird_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);
  localparam int unsigned IDX_W = $clog2(FRAME_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS);

  logic                   recv_r, recv_nxt;
  logic [FRAME_BITS-1:0]  shift_r, shift_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   ovalid_r, ovalid_nxt;
  ird_event_t             ev_r, ev_nxt;
  logic [FRAME_W-1:0]     frame_r, frame_nxt;
  logic                   fvalid_nxt, fvalid_r;

  assign q_pop = q_avail && (!ovalid_r || out_tready);

  always_comb begin
    recv_nxt   = recv_r;
    shift_nxt  = shift_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ev_nxt     = ev_r;
    frame_nxt  = frame_r;
    if (q_pop) begin
      ovalid_nxt = 1'b1;
      frame_nxt  = '0;
      if (q_class.first) begin
        ev_nxt = EV_FIRST;
      end else if (!recv_r) begin
        if (q_class.hdr) begin
          ev_nxt    = EV_HEADER;
          recv_nxt  = 1'b1;
          shift_nxt = '0;
          cnt_nxt   = '0;
        end else if (q_class.rpt) begin
          ev_nxt = EV_REPEAT;
        end else begin
          ev_nxt = EV_IGNORE;
        end
      end else if (q_class.zero || q_class.one) begin
        shift_nxt[cnt_r[IDX_W-1:0]] = shift_r[cnt_r[IDX_W-1:0]] | (!q_class.zero);
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_nxt == CNT_LAST) begin
          ev_nxt    = EV_FRAME;
          recv_nxt  = 1'b0;
          frame_nxt = FRAME_W'(shift_nxt);
        end else begin
          ev_nxt = EV_BIT;
        end
      end else if (q_class.hdr) begin
        ev_nxt    = EV_HEADER;
        shift_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        ev_nxt   = EV_ERROR;
        recv_nxt = 1'b0;
      end
    end
    fvalid_nxt = (ev_nxt == EV_FRAME)
              && ((frame_nxt[7:0] ^ frame_nxt[15:8]) == BYTE_ONES)
              && ((frame_nxt[23:16] ^ frame_nxt[31:24]) == BYTE_ONES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_r   <= 1'b0;
      shift_r  <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      recv_r   <= recv_nxt;
      shift_r  <= shift_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r     <= ev_nxt;
    frame_r  <= frame_nxt;
    fvalid_r <= fvalid_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ev_r;
  assign out_tdata  = {7'd0, fvalid_r, frame_r[23:16], frame_r[7:0], frame_r};

endmodule
`default_nettype wire

/* hdl/ir_pulse_distance_decoder_top.sv */
// Path: the front end classifies an accepted edge, the queue holds it and the back end
// registers its result. Throughput: one edge per cycle while out_tready stays high; the
// window compares in the front end are combinational and the back end registers each bit.
// Reset: synchronous, active low; windows return to their defaults, the decoder
// goes idle and waits for a first edge.
// Depends on ird_pkg, ird_front, ird_queue and ird_back.
`default_nettype none
module ir_pulse_distance_decoder_top #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ird_pkg::REG_IDX_W-1:0]     cfg_index,
  input  wire logic [ird_pkg::TIME_W-1:0]        cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // edge_time[15:0]
  input  wire logic [ird_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // frame_bits[31:0], address[39:32], command[47:40], frame_valid[48], zero[55:49]
  output logic [ird_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // event_res[2:0]
  output logic [ird_pkg::OUT_TUSER_W-1:0]        out_tuser
);
  import ird_pkg::*;

  logic       q_push, q_full, q_pop, q_avail;
  ird_class_t push_class, pop_class;

  ird_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .edge_time (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_class   (push_class)
  );

  ird_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_class),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (pop_class)
  );

  ird_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_avail    (q_avail),
    .q_class    (pop_class),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* sim/ird_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the IR pulse-distance decoder: tracks window writes and edge words,
// predicts each result word and compares it field by field. Depends on ird_pkg.
module ird_checker #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ird_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [ird_pkg::TIME_W-1:0]      cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ird_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ird_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [ird_pkg::OUT_TUSER_W-1:0] out_tuser,
  output int                              fail_count,
  output int                              pending_count
);
  import ird_pkg::*;

  typedef struct {
    ird_event_t         ev;
    logic [FRAME_W-1:0] bits;
    logic [BYTE_W-1:0]  addr;
    logic [BYTE_W-1:0]  cmd;
    logic               ok;
  } decoded_edge_t;

  decoded_edge_t      decoded_q[$];
  logic [TIME_W-1:0]  win [NUM_REGS];
  logic               have_edge;
  logic [TIME_W-1:0]  last_stamp;
  logic               in_frame;
  logic [FRAME_W-1:0] frame_acc;
  logic [5:0]         frame_len;

  function automatic logic hits(input logic [TIME_W-1:0] span, input ird_reg_t lo_reg,
                                input ird_reg_t hi_reg);
    return span >= win[lo_reg] && span <= win[hi_reg];
  endfunction

  function automatic void open_frame();
    in_frame  = 1'b1;
    frame_acc = '0;
    frame_len = '0;
  endfunction

  function automatic decoded_edge_t decode_edge(input logic [TIME_W-1:0] stamp);
    decoded_edge_t     r;
    logic [TIME_W-1:0] span;
    logic              bit_val;
    r.ev   = EV_IGNORE;
    r.bits = '0;
    r.addr = '0;
    r.cmd  = '0;
    r.ok   = 1'b0;
    if (!have_edge) begin
      have_edge  = 1'b1;
      last_stamp = stamp;
      r.ev       = EV_FIRST;
      return r;
    end
    span       = stamp - last_stamp;
    last_stamp = stamp;
    if (!in_frame) begin
      if (hits(span, REG_HEADER_MIN, REG_HEADER_MAX)) begin
        open_frame();
        r.ev = EV_HEADER;
      end else if (hits(span, REG_REPEAT_MIN, REG_REPEAT_MAX)) begin
        r.ev = EV_REPEAT;
      end
      return r;
    end
    if (hits(span, REG_ZERO_MIN, REG_ZERO_MAX)) begin
      bit_val = 1'b0;
    end else if (hits(span, REG_ONE_MIN, REG_ONE_MAX)) begin
      bit_val = 1'b1;
    end else if (hits(span, REG_HEADER_MIN, REG_HEADER_MAX)) begin
      open_frame();
      r.ev = EV_HEADER;
      return r;
    end else begin
      in_frame = 1'b0;
      r.ev     = EV_ERROR;
      return r;
    end
    if (frame_len < FRAME_W) frame_acc[frame_len[4:0]] = frame_acc[frame_len[4:0]] | bit_val;
    if (frame_len < 6'd63) frame_len = frame_len + 6'd1;
    if (frame_len >= FRAME_BITS) begin
      in_frame = 1'b0;
      r.ev     = EV_FRAME;
      r.bits   = frame_acc;
      r.addr   = frame_acc[7:0];
      r.cmd    = frame_acc[23:16];
      r.ok     = ((frame_acc[7:0] ^ frame_acc[15:8]) == BYTE_ONES) &&
                 ((frame_acc[23:16] ^ frame_acc[31:24]) == BYTE_ONES);
    end else begin
      r.ev = EV_BIT;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [FRAME_W-1:0] want,
                                      input logic [FRAME_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    decoded_edge_t want;
    if (!rst_n) begin
      win[REG_HEADER_MIN] = RST_HEADER_MIN;
      win[REG_HEADER_MAX] = RST_HEADER_MAX;
      win[REG_REPEAT_MIN] = RST_REPEAT_MIN;
      win[REG_REPEAT_MAX] = RST_REPEAT_MAX;
      win[REG_ZERO_MIN]   = RST_ZERO_MIN;
      win[REG_ZERO_MAX]   = RST_ZERO_MAX;
      win[REG_ONE_MIN]    = RST_ONE_MIN;
      win[REG_ONE_MAX]    = RST_ONE_MAX;
      have_edge  = 1'b0;
      last_stamp = '0;
      in_frame   = 1'b0;
      frame_acc  = '0;
      frame_len  = '0;
      decoded_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $error("result word with nothing pending: event_res %0d", out_tuser);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("event_res", FRAME_W'(want.ev), FRAME_W'(out_tuser));
          check_field("frame_bits", want.bits, out_tdata[31:0]);
          check_field("address", FRAME_W'(want.addr), FRAME_W'(out_tdata[39:32]));
          check_field("command", FRAME_W'(want.cmd), FRAME_W'(out_tdata[47:40]));
          check_field("frame_valid", FRAME_W'(want.ok), FRAME_W'(out_tdata[48]));
        end
      end
      if (cfg_we) win[cfg_index] = cfg_wdata;
      if (in_tvalid && in_tready) decoded_q.push_back(decode_edge(in_tdata[TIME_W-1:0]));
    end
    pending_count = decoded_q.size();
  end

endmodule

/* sim/tb_ir_pulse_distance_decoder_top.sv */
`timescale 1ns / 100ps
// Testbench top for the IR pulse-distance decoder: drives edge timestamps and window
// writes under several idle patterns. Depends on ird_pkg, ird_checker and ir_pulse_distance_decoder_top.
module tb_ir_pulse_distance_decoder_top;
  import ird_pkg::*;

  localparam int unsigned FRAME_BITS     = 32;
  localparam int unsigned STALL_LIMIT    = 4000;
  localparam int unsigned RANDOM_PER_SET = 80;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [REG_IDX_W-1:0]   cfg_index;
  logic [TIME_W-1:0]      cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int                fail_count;
  int                pending_count;
  int                send_idle_pct;
  int                ready_stall_pct;
  int                quiet_cycles;
  int                sent_edges;
  logic [TIME_W-1:0] stamp;
  logic [TIME_W-1:0] win [NUM_REGS];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ir_pulse_distance_decoder_top #(
    .FRAME_BITS(FRAME_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  ird_checker #(
    .FRAME_BITS(FRAME_BITS)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= ready_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_edge(input logic [TIME_W-1:0] t);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_edges++;
  endtask

  task automatic gap(input logic [TIME_W-1:0] span);
    stamp = stamp + span;
    send_edge(stamp);
  endtask

  function automatic logic [TIME_W-1:0] pick_span(input ird_reg_t lo_reg, input ird_reg_t hi_reg);
    if (win[lo_reg] <= win[hi_reg]) return TIME_W'($urandom_range(win[hi_reg], win[lo_reg]));
    return TIME_W'($urandom);
  endfunction

  task automatic send_frame(input logic [FRAME_W-1:0] bits, input int nbits);
    gap(pick_span(REG_HEADER_MIN, REG_HEADER_MAX));
    for (int i = 0; i < nbits; i++) begin
      if (bits[i]) gap(pick_span(REG_ONE_MIN, REG_ONE_MAX));
      else gap(pick_span(REG_ZERO_MIN, REG_ZERO_MAX));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_windows(input logic [TIME_W-1:0] h_lo, h_hi, r_lo, r_hi,
                              z_lo, z_hi, o_lo, o_hi);
    win[REG_HEADER_MIN] = h_lo;
    win[REG_HEADER_MAX] = h_hi;
    win[REG_REPEAT_MIN] = r_lo;
    win[REG_REPEAT_MAX] = r_hi;
    win[REG_ZERO_MIN]   = z_lo;
    win[REG_ZERO_MAX]   = z_hi;
    win[REG_ONE_MIN]    = o_lo;
    win[REG_ONE_MAX]    = o_hi;
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= ird_reg_t'(i);
      cfg_wdata <= win[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // window edges, counter wrap, restart and errors under the reset windows
  task automatic run_directed();
    stamp = 16'hFFFF;
    send_edge(stamp);
    gap(16'd12500);
    gap(16'd900);
    gap(16'd1400);
    gap(16'd1900);
    gap(16'd2600);
    gap(16'd14500);
    gap(16'd1401);
    gap(16'd10800);
    gap(16'd11800);
    gap(16'd12499);
    gap(16'd14501);
    gap(16'd0);
    gap(16'hFFFF);
    gap(16'd10799);
    gap(16'd11801);
    gap(16'd12500);
    gap(16'd899);
    gap(16'd12500);
    gap(16'd2601);
  endtask

  task automatic run_random(input int count);
    int               target;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] cmd;
    target = sent_edges + count;
    while (sent_edges < target) begin
      case ($urandom_range(9, 0))
        0, 1, 2: begin
          addr = BYTE_W'($urandom);
          cmd  = BYTE_W'($urandom);
          send_frame({~cmd, cmd, ~addr, addr}, FRAME_BITS);
        end
        3, 4: send_frame(FRAME_W'($urandom), FRAME_BITS);
        5: gap(pick_span(REG_REPEAT_MIN, REG_REPEAT_MAX));
        6: begin
          send_frame(FRAME_W'($urandom), $urandom_range(31, 0));
          gap(TIME_W'($urandom));
        end
        7: gap(TIME_W'($urandom));
        8: begin
          send_frame(FRAME_W'($urandom), $urandom_range(20, 0));
          send_frame(FRAME_W'($urandom), FRAME_BITS);
        end
        default: begin
          stamp = TIME_W'($urandom);
          send_edge(stamp);
        end
      endcase
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    out_tready      = 1'b0;
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    quiet_cycles    = 0;
    sent_edges      = 0;
    stamp           = '0;
    win[REG_HEADER_MIN] = RST_HEADER_MIN;
    win[REG_HEADER_MAX] = RST_HEADER_MAX;
    win[REG_REPEAT_MIN] = RST_REPEAT_MIN;
    win[REG_REPEAT_MAX] = RST_REPEAT_MAX;
    win[REG_ZERO_MIN]   = RST_ZERO_MIN;
    win[REG_ZERO_MAX]   = RST_ZERO_MAX;
    win[REG_ONE_MIN]    = RST_ONE_MIN;
    win[REG_ONE_MAX]    = RST_ONE_MAX;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(RANDOM_PER_SET);

    drain();
    load_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    send_idle_pct = 87;
    run_random(RANDOM_PER_SET);

    // empty repeat window, zero and one windows overlap
    drain();
    load_windows(16'd5000, 16'd6000, 16'd9000, 16'd8000, 16'd100, 16'd700, 16'd500, 16'd1500);
    send_idle_pct   = 0;
    ready_stall_pct = 87;
    run_random(RANDOM_PER_SET);

    drain();
    load_windows(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_idle_pct   = 38;
    ready_stall_pct = 38;
    run_random(RANDOM_PER_SET);

    drain();
    load_windows(16'd60000, 16'hFFFF, 16'd50000, 16'd59999, 16'd30000, 16'd31000,
                 16'd40000, 16'd45000);
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    run_random(RANDOM_PER_SET);

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/ird_pkg.sv
hdl/ird_front.sv
hdl/ird_queue.sv
hdl/ird_back.sv
hdl/ir_pulse_distance_decoder_top.sv
sim/ird_checker.sv
sim/tb_ir_pulse_distance_decoder_top.sv
